[hdl/u16u8_pkg.sv]
// shared types, constants and the code point encoder for the utf-16 to utf-8 transcoder
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

    localparam int COUNT_W          = 13;
    localparam int COUNT_FIELD_MAX  = 8191;
    localparam int MAX_STRING_BYTES_DEF = 4096;
    // at most six utf-8 bytes come out of one code unit, plus the terminator
    localparam int BURST_BYTES      = 6;
    localparam int BURST_W          = BURST_BYTES * 8;

    localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
    localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [20:0] CP_LIMIT      = 21'h110000;
    localparam logic [20:0] TWO_BYTE_MIN  = 21'h80;
    localparam logic [20:0] THREE_BYTE_MIN = 21'h800;
    localparam logic [20:0] PRINT_MIN     = 21'h20;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       last_unit;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               run_last;
        logic               terminator;
        logic [COUNT_W-1:0] total_bytes;
    } out_item_t;

    // encoded code point: first byte in the low bits
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } enc_t;

    // all results of one code unit, handed from the decoder to the sequencer
    typedef struct packed {
        logic [BURST_W-1:0] bytes;
        logic [2:0]         nbytes;
        logic               term;
        logic [COUNT_W-1:0] count;
    } burst_t;

    function automatic enc_t encode_point(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        e.len   = '0;
        if (cp < TWO_BYTE_MIN) begin
            if (cp >= PRINT_MIN) begin
                e.bytes[7:0] = cp[7:0];
                e.len        = 3'd1;
            end
        end else if (cp < THREE_BYTE_MIN) begin
            e.bytes[7:0]  = {3'b110, cp[10:6]};
            e.bytes[15:8] = {2'b10, cp[5:0]};
            e.len         = 3'd2;
        end else if (cp < SUPP_BASE) begin
            e.bytes[7:0]   = {4'b1110, cp[15:12]};
            e.bytes[15:8]  = {2'b10, cp[11:6]};
            e.bytes[23:16] = {2'b10, cp[5:0]};
            e.len          = 3'd3;
        end else if (cp < CP_LIMIT) begin
            e.bytes[7:0]   = {5'b11110, cp[20:18]};
            e.bytes[15:8]  = {2'b10, cp[17:12]};
            e.bytes[23:16] = {2'b10, cp[11:6]};
            e.bytes[31:24] = {2'b10, cp[5:0]};
            e.len          = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

[hdl/u16u8_in_stage.sv]
// input register for code unit transactions
// depends on u16u8_pkg
`timescale 1ns / 1ps
`default_nettype none

module u16u8_in_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire u16u8_pkg::in_item_t  s_data,
    output logic                      item_valid,
    output u16u8_pkg::in_item_t       item,
    input  wire logic                 item_take
);

    logic                valid_reg;
    logic                valid_next;
    u16u8_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

[hdl/u16u8_decode.sv]
// code unit decoder: surrogate pairing, string state, byte count and mode register
// depends on u16u8_pkg
`timescale 1ns / 1ps
`default_nettype none

module u16u8_decode #(
    parameter int MAX_STRING_BYTES = u16u8_pkg::MAX_STRING_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire u16u8_pkg::in_item_t  item,
    input  wire logic                 item_take,
    output u16u8_pkg::burst_t         burst
);

    localparam logic [u16u8_pkg::COUNT_W-1:0] COUNT_LIMIT = u16u8_pkg::COUNT_W'(
        (MAX_STRING_BYTES < u16u8_pkg::COUNT_FIELD_MAX) ? MAX_STRING_BYTES
                                                         : u16u8_pkg::COUNT_FIELD_MAX);

    logic                          big_endian_reg;
    logic [9:0]                    held_reg;
    logic [9:0]                    held_next;
    logic                          held_valid_reg;
    logic                          held_valid_next;
    logic                          stopped_reg;
    logic                          stopped_next;
    logic [u16u8_pkg::COUNT_W-1:0] count_reg;
    logic [u16u8_pkg::COUNT_W-1:0] count_next;

    logic [15:0]                   unit;
    logic                          is_hi;
    logic                          is_lo;
    u16u8_pkg::enc_t               enc_a;
    u16u8_pkg::enc_t               enc_b;
    u16u8_pkg::enc_t               enc_c;
    logic                          use_a;
    logic                          use_b;
    logic                          use_c;
    logic [20:0]                   cp_a;
    logic [2:0]                    len_a;
    logic [2:0]                    len_b;
    logic [2:0]                    len_c;
    logic [2:0]                    nbytes;
    logic [u16u8_pkg::COUNT_W:0]   count_sum;
    logic [u16u8_pkg::COUNT_W-1:0] count_sat;

    assign unit  = big_endian_reg ? {item.first_byte, item.second_byte}
                                  : {item.second_byte, item.first_byte};
    assign is_hi = (unit >= u16u8_pkg::HI_SURR_FIRST) && (unit <= u16u8_pkg::HI_SURR_LAST);
    assign is_lo = (unit >= u16u8_pkg::LO_SURR_FIRST) && (unit <= u16u8_pkg::LO_SURR_LAST);

    // slot a: the held surrogate (paired or alone), slot b: this unit,
    // slot c: a high surrogate arriving on the last unit
    always_comb begin
        use_a           = 1'b0;
        use_b           = 1'b0;
        use_c           = 1'b0;
        cp_a            = u16u8_pkg::SUPP_BASE + {1'b0, held_reg, unit[9:0]};
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        stopped_next    = stopped_reg;
        if (!stopped_reg) begin
            if (held_valid_reg) begin
                use_a           = 1'b1;
                held_valid_next = 1'b0;
                held_next       = '0;
                if (!is_lo) begin
                    cp_a = {5'd0, u16u8_pkg::HI_SURR_FIRST | {6'd0, held_reg}};
                end
            end
            if (!(held_valid_reg && is_lo)) begin
                if (unit == '0) begin
                    stopped_next = 1'b1;
                end else if (is_hi) begin
                    held_next       = unit[9:0];
                    held_valid_next = 1'b1;
                end else begin
                    use_b = 1'b1;
                end
            end
        end
        if (item.last_unit) begin
            use_c           = held_valid_next;
            held_next       = '0;
            held_valid_next = 1'b0;
            stopped_next    = 1'b0;
        end
    end

    assign enc_a = u16u8_pkg::encode_point(cp_a);
    assign enc_b = u16u8_pkg::encode_point({5'd0, unit});
    assign enc_c = u16u8_pkg::encode_point({5'd0, unit});

    assign len_a  = use_a ? enc_a.len : 3'd0;
    assign len_b  = use_b ? enc_b.len : 3'd0;
    assign len_c  = use_c ? enc_c.len : 3'd0;
    assign nbytes = len_a + len_b + len_c;

    assign count_sum = {1'b0, count_reg} + {{(u16u8_pkg::COUNT_W - 2){1'b0}}, nbytes};
    assign count_sat = (count_sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT
                                                         : count_sum[u16u8_pkg::COUNT_W-1:0];

    always_comb begin
        burst.bytes  = '0;
        burst.nbytes = nbytes;
        burst.term   = item.last_unit;
        burst.count  = count_sat;
        if (use_a) begin
            burst.bytes = burst.bytes | u16u8_pkg::BURST_W'(enc_a.bytes);
        end
        if (use_b) begin
            burst.bytes = burst.bytes | (u16u8_pkg::BURST_W'(enc_b.bytes) << {len_a, 3'b000});
        end
        if (use_c) begin
            burst.bytes = burst.bytes | (u16u8_pkg::BURST_W'(enc_c.bytes) << {len_a, 3'b000});
        end
    end

    assign count_next = item.last_unit ? '0 : count_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                big_endian_reg <= cfg_wr_data;
            end
            if (item_take) begin
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                stopped_reg    <= stopped_next;
                count_reg      <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/u16u8_out_seq.sv]
// result register and byte sequencer: plays out one decoded burst, one byte per cycle while m_ready is high
// depends on u16u8_pkg
`timescale 1ns / 1ps
`default_nettype none

module u16u8_out_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_valid,
    output logic                     item_take,
    input  wire u16u8_pkg::burst_t   burst,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output u16u8_pkg::out_item_t     m_data
);

    u16u8_pkg::burst_t burst_reg;
    logic [2:0]        total_reg;
    logic [2:0]        total_next;
    logic [2:0]        idx_reg;
    logic [2:0]        idx_next;
    logic [2:0]        burst_total;
    logic              last_beat;
    logic              can_load;
    logic              is_term_beat;
    logic [u16u8_pkg::BURST_W-1:0] shifted;

    assign burst_total = burst.nbytes + {2'b00, burst.term};
    assign last_beat   = (idx_reg == total_reg - 3'd1);
    assign can_load    = (total_reg == '0) || (m_ready && last_beat);
    assign item_take   = item_valid && can_load;

    assign m_valid      = (total_reg != '0);
    assign is_term_beat = burst_reg.term && (idx_reg == burst_reg.nbytes);
    assign shifted      = burst_reg.bytes >> {idx_reg, 3'b000};

    always_comb begin
        m_data.out_byte    = is_term_beat ? 8'd0 : shifted[7:0];
        m_data.run_last    = last_beat;
        m_data.terminator  = is_term_beat;
        m_data.total_bytes = is_term_beat ? burst_reg.count : '0;
    end

    always_comb begin
        total_next = total_reg;
        idx_next   = idx_reg;
        if (item_take) begin
            total_next = burst_total;
            idx_next   = '0;
        end else if (m_valid && m_ready) begin
            if (last_beat) begin
                total_next = '0;
                idx_next   = '0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            idx_reg   <= '0;
        end else begin
            total_reg <= total_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            burst_reg <= burst;
        end
    end

endmodule

`default_nettype wire

[hdl/utf16_to_utf8_transcoder_core.sv]
// UTF-16 to UTF-8 transcoder. Each input transaction carries one UTF-16 code
// unit as two bytes in stream order; cfg_wr_data written with cfg_wr_en picks
// the byte order (0: first byte is the low half, 1: first byte is the high
// half). The block emits one UTF-8 byte per output transaction, drops code
// points below 0x20, pairs a high surrogate with a following low surrogate
// (otherwise encodes it alone as three bytes), stops the string at a zero unit
// and, on the unit marked last_unit, sends a terminator transaction carrying
// the saturating byte count. run_last flags the final output of each input.
// Timing: a unit enters an input register, is decoded combinationally, and its
// results are played out by the byte sequencer at one per cycle while m_ready
// is high; a unit yields k results (0 to 7, typically 1 to 3). A waiting unit's
// burst is loaded as the last byte goes out. Between input acceptance and the
// first output lie the input register and the sequencer's burst register.
// depends on u16u8_pkg, u16u8_in_stage, u16u8_decode, u16u8_out_seq
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder_core #(
    parameter int MAX_STRING_BYTES = u16u8_pkg::MAX_STRING_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire u16u8_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output u16u8_pkg::out_item_t      m_data
);

    logic                item_valid;
    logic                item_take;
    u16u8_pkg::in_item_t item;
    u16u8_pkg::burst_t   burst;

    u16u8_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    u16u8_decode #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .item_take   (item_take),
        .burst       (burst)
    );

    u16u8_out_seq u_out_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_take  (item_take),
        .burst      (burst),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
